FILE: hw/rtl/hvn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvn_pkg
// Shared types, widths, register codes and neighbor tables for the height-map
// vertex normal core.
// ----------------------------------------------------------------------------
package hvn_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int ROW_LIMIT     = 4096;

  localparam int HGT_W   = 8;
  localparam int COL_W   = 10;
  localparam int ROW_W   = 12;
  localparam int NRM_W   = 16;
  localparam int IW_W    = 11;
  localparam int IH_W    = 13;
  localparam int CFG_DW  = 13;
  localparam int CFG_IW  = 1;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 72;

  // Root search: result 0..16384 needs 15 bits.
  localparam int Q_W     = 15;
  localparam int ONE_Q14 = 16384;
  localparam int SQ_W    = 37;
  localparam int T_W     = 39;
  localparam int SUM_W   = 20;
  localparam int D2_W    = 17;
  localparam int ACC_W   = 72;
  localparam int PRD_W   = 32;

  localparam logic [CFG_IW-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IW-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [IW_W-1:0] IMAGE_WIDTH_RST  = 11'd256;
  localparam logic [IH_W-1:0] IMAGE_HEIGHT_RST = 13'd256;

  localparam logic [3:0] NB_CENTER = 4'd4;

  typedef enum logic [1:0] {T_IDLE, T_READ, T_CALC, T_EMIT} top_state_t;

  typedef enum logic [3:0] {
    E_IDLE, E_DY, E_T, E_UROOT, E_UWAIT, E_UWR, E_RA, E_RB,
    E_LB, E_MUL, E_ACC, E_SQ, E_SQACC, E_NCHK, E_NROOT, E_NWAIT
  } eng_state_t;

  typedef struct packed {
    logic signed [NRM_W-1:0] x;
    logic signed [NRM_W-1:0] y;
    logic signed [NRM_W-1:0] z;
  } normal_t;

  // Window heights, flat index (row)*3 + (col), row 0 is the oldest line.
  typedef struct packed {
    logic                  start;
    logic [8:0][HGT_W-1:0] h;
  } eng_req_t;

  typedef struct packed {
    logic    done;
    normal_t n;
  } eng_rsp_t;

  // Neighbors in order E, W, N, S, NE, SW, SE, NW.
  function automatic logic signed [1:0] nb_dx(input logic [2:0] i);
    logic signed [1:0] v;
    case (i)
      3'd0, 3'd4, 3'd6: v = 2'sd1;
      3'd1, 3'd5, 3'd7: v = -2'sd1;
      default:          v = 2'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [1:0] nb_dz(input logic [2:0] i);
    logic signed [1:0] v;
    case (i)
      3'd3, 3'd5, 3'd6: v = 2'sd1;
      3'd2, 3'd4, 3'd7: v = -2'sd1;
      default:          v = 2'sd0;
    endcase
    return v;
  endfunction

  function automatic logic [3:0] nb_pos(input logic [2:0] i);
    logic [3:0] v;
    case (i)
      3'd0:    v = 4'd5;
      3'd1:    v = 4'd3;
      3'd2:    v = 4'd1;
      3'd3:    v = 4'd7;
      3'd4:    v = 4'd2;
      3'd5:    v = 4'd6;
      3'd6:    v = 4'd8;
      default: v = 4'd0;
    endcase
    return v;
  endfunction

  function automatic logic [2:0] pair_a(input logic [2:0] i);
    logic [2:0] v;
    case (i)
      3'd0:    v = 3'd0;
      3'd1:    v = 3'd3;
      3'd2:    v = 3'd7;
      3'd3:    v = 3'd7;
      3'd4:    v = 3'd1;
      3'd5:    v = 3'd2;
      default: v = 3'd6;
    endcase
    return v;
  endfunction

  function automatic logic [2:0] pair_b(input logic [2:0] i);
    logic [2:0] v;
    case (i)
      3'd0, 3'd1: v = 3'd4;
      3'd2:       v = 3'd3;
      3'd3:       v = 3'd1;
      3'd4, 3'd5: v = 3'd5;
      3'd6:       v = 3'd2;
      default:    v = 3'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: hw/rtl/hvn_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvn_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module hvn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/hvn_root.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvn_root
// Iterative scaled root: largest m in [0, 16384] with
// (2m-1)^2 * t <= num_sq * 2^30, one result bit per cycle.
// ----------------------------------------------------------------------------
module hvn_root
  import hvn_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [SQ_W-1:0] num_sq,
  input  logic [T_W-1:0]  t_in,
  output logic            done,
  output logic [Q_W-1:0]  root
);

  localparam int KT_SH = Q_W + 1;
  localparam int T2_SH = 2 * Q_W;

  logic                    busy_r, busy_nxt;
  logic                    done_r, done_nxt;
  logic [Q_W-1:0]          m_r, m_nxt;
  logic [Q_W-1:0]          bm_r, bm_nxt;
  logic signed [ACC_W-1:0] p_r, p_nxt;
  logic signed [ACC_W-1:0] kt_r, kt_nxt;
  logic signed [ACC_W-1:0] t2_r, t2_nxt;
  logic signed [ACC_W-1:0] rsh_r, rsh_nxt;
  logic signed [ACC_W-1:0] pc, tx, kt_acc;
  logic                    take;

  // P tracks k^2*t for k = 2m-1; the trial adds the cross and square terms
  // kept pre-shifted so that no barrel shifter is needed.
  always_comb begin
    tx       = $signed({{(ACC_W-T_W){1'b0}}, t_in});
    pc       = p_r + kt_r + t2_r;
    take     = !m_r[Q_W-1] && (pc <= rsh_r);
    kt_acc   = kt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    m_nxt    = m_r;
    bm_nxt   = bm_r;
    p_nxt    = p_r;
    kt_nxt   = kt_r;
    t2_nxt   = t2_r;
    rsh_nxt  = rsh_r;
    if (start) begin
      busy_nxt = 1'b1;
      m_nxt    = '0;
      bm_nxt   = {1'b1, {(Q_W-1){1'b0}}};
      p_nxt    = tx;
      kt_nxt   = -(tx <<< KT_SH);
      t2_nxt   = tx <<< T2_SH;
      rsh_nxt  = $signed({{(ACC_W-SQ_W){1'b0}}, num_sq}) <<< T2_SH;
    end else if (busy_r) begin
      if (take) begin
        m_nxt  = m_r | bm_r;
        p_nxt  = pc;
        kt_acc = kt_r + (t2_r <<< 1);
      end
      kt_nxt = kt_acc >>> 1;
      t2_nxt = t2_r >>> 2;
      bm_nxt = bm_r >> 1;
      if (bm_r[0]) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    m_r   <= m_nxt;
    bm_r  <= bm_nxt;
    p_r   <= p_nxt;
    kt_r  <= kt_nxt;
    t2_r  <= t2_nxt;
    rsh_r <= rsh_nxt;
  end

  assign done = done_r;
  assign root = m_r;

endmodule

FILE: hw/rtl/hvn_normal.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvn_normal
// Sequential normal engine: eight unit difference vectors into a small RAM,
// eight cross products accumulated, then normalization of the sum.
// ----------------------------------------------------------------------------
module hvn_normal
  import hvn_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  eng_req_t req,
  output eng_rsp_t rsp
);

  eng_state_t st_r, st_nxt;

  logic [8:0][HGT_W-1:0]   h_r;
  logic [2:0]              i_r;
  logic [1:0]              ci_r;
  logic [15:0]             dysq_r;
  logic                    dyneg_r;
  logic [D2_W-1:0]         d2_r;
  normal_t                 uvec_r, ua_r, ub_r, n_r;
  logic signed [PRD_W-1:0] p1_r, p2_r;
  logic signed [SUM_W-1:0] s_r [3];
  logic [SQ_W-1:0]         sq_r [3];
  logic [SQ_W-1:0]         sqp_r;
  logic [T_W-1:0]          t_r;
  logic                    done_r;

  logic signed [1:0]       dx, dz;
  logic signed [8:0]       dy;
  logic signed [17:0]      dy_prod;
  logic                    root_start, root_done;
  logic [SQ_W-1:0]         root_num;
  logic [T_W-1:0]          root_t;
  logic [Q_W-1:0]          root_val;
  logic signed [NRM_W-1:0] root_s, root_sgn;
  logic                    root_neg;
  logic [2:0]              uraddr;
  normal_t                 urdata;
  logic signed [NRM_W-1:0] op1a, op1b, op2a, op2b;
  logic signed [PRD_W-1:0] diff, dmag;
  logic [PRD_W-1:0]        drnd;
  logic signed [SUM_W-1:0] dq;
  logic signed [39:0]      s_prod;

  always_comb begin
    dx      = nb_dx(i_r);
    dz      = nb_dz(i_r);
    dy      = $signed({1'b0, h_r[nb_pos(i_r)]}) - $signed({1'b0, h_r[NB_CENTER]});
    dy_prod = dy * dy;
    s_prod  = s_r[ci_r] * s_r[ci_r];
  end

  // Root request: unit components first, output components at the end.
  always_comb begin
    root_start = (st_r == E_UROOT) || (st_r == E_NROOT);
    if (st_r == E_NROOT) begin
      root_num = sq_r[ci_r];
      root_t   = t_r;
    end else begin
      case (ci_r)
        2'd0:    root_num = SQ_W'(dx != 2'sd0);
        2'd1:    root_num = SQ_W'(dysq_r);
        default: root_num = SQ_W'(dz != 2'sd0);
      endcase
      root_t = T_W'(d2_r);
    end
    if (st_r == E_NWAIT) begin
      root_neg = s_r[ci_r][SUM_W-1];
    end else begin
      case (ci_r)
        2'd0:    root_neg = dx[1];
        2'd1:    root_neg = dyneg_r;
        default: root_neg = dz[1];
      endcase
    end
    root_s   = $signed(NRM_W'(root_val));
    root_sgn = root_neg ? -root_s : root_s;
  end

  hvn_root u_root (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (root_start),
    .num_sq (root_num),
    .t_in   (root_t),
    .done   (root_done),
    .root   (root_val)
  );

  assign uraddr = (st_r == E_RA) ? pair_a(i_r) : pair_b(i_r);

  hvn_ram #(
    .WIDTH ($bits(normal_t)),
    .DEPTH (8)
  ) u_uvec_ram (
    .clk   (clk),
    .we    (st_r == E_UWR),
    .waddr (i_r),
    .wdata (uvec_r),
    .raddr (uraddr),
    .rdata (urdata)
  );

  // Cross product operands for component ci of a x b.
  always_comb begin
    case (ci_r)
      2'd0: begin
        op1a = ua_r.y; op1b = ub_r.z; op2a = ua_r.z; op2b = ub_r.y;
      end
      2'd1: begin
        op1a = ua_r.z; op1b = ub_r.x; op2a = ua_r.x; op2b = ub_r.z;
      end
      default: begin
        op1a = ua_r.x; op1b = ub_r.y; op2a = ua_r.y; op2b = ub_r.x;
      end
    endcase
    diff = p1_r - p2_r;
    dmag = diff[PRD_W-1] ? -diff : diff;
    drnd = (PRD_W'(dmag) + PRD_W'(8192)) >> 14;
    dq   = diff[PRD_W-1] ? -$signed(drnd[SUM_W-1:0]) : $signed(drnd[SUM_W-1:0]);
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      E_IDLE:   if (req.start) st_nxt = E_DY;
      E_DY:     st_nxt = E_T;
      E_T:      st_nxt = E_UROOT;
      E_UROOT:  st_nxt = E_UWAIT;
      E_UWAIT:  if (root_done) st_nxt = (ci_r == 2'd2) ? E_UWR : E_UROOT;
      E_UWR:    st_nxt = (i_r == 3'd7) ? E_RA : E_DY;
      E_RA:     st_nxt = E_RB;
      E_RB:     st_nxt = E_LB;
      E_LB:     st_nxt = E_MUL;
      E_MUL:    st_nxt = E_ACC;
      E_ACC: begin
        if (ci_r != 2'd2) begin
          st_nxt = E_MUL;
        end else begin
          st_nxt = (i_r == 3'd7) ? E_SQ : E_RA;
        end
      end
      E_SQ:     st_nxt = E_SQACC;
      E_SQACC:  st_nxt = (ci_r == 2'd2) ? E_NCHK : E_SQ;
      E_NCHK:   st_nxt = (t_r == '0) ? E_IDLE : E_NROOT;
      E_NROOT:  st_nxt = E_NWAIT;
      E_NWAIT:  if (root_done) st_nxt = (ci_r == 2'd2) ? E_IDLE : E_NROOT;
      default:  st_nxt = E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= E_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= ((st_r == E_NCHK) && (t_r == '0)) ||
                ((st_r == E_NWAIT) && root_done && (ci_r == 2'd2));
    end
    case (st_r)
      E_IDLE: begin
        h_r  <= req.h;
        i_r  <= '0;
        ci_r <= '0;
        t_r  <= '0;
        for (int k = 0; k < 3; k++) begin
          s_r[k] <= '0;
        end
      end
      E_DY: begin
        dysq_r  <= dy_prod[15:0];
        dyneg_r <= dy[8];
        ci_r    <= '0;
      end
      E_T: d2_r <= D2_W'(dx != 2'sd0) + D2_W'(dz != 2'sd0) + D2_W'(dysq_r);
      E_UWAIT: begin
        if (root_done) begin
          case (ci_r)
            2'd0:    uvec_r.x <= root_sgn;
            2'd1:    uvec_r.y <= root_sgn;
            default: uvec_r.z <= root_sgn;
          endcase
          ci_r <= ci_r + 2'd1;
        end
      end
      E_UWR: i_r <= i_r + 3'd1;
      E_RB:  ua_r <= urdata;
      E_LB: begin
        ub_r <= urdata;
        ci_r <= '0;
      end
      E_MUL: begin
        p1_r <= op1a * op1b;
        p2_r <= op2a * op2b;
      end
      E_ACC: begin
        s_r[ci_r] <= s_r[ci_r] + dq;
        if (ci_r == 2'd2) begin
          i_r  <= i_r + 3'd1;
          ci_r <= '0;
        end else begin
          ci_r <= ci_r + 2'd1;
        end
      end
      E_SQ: sqp_r <= s_prod[SQ_W-1:0];
      E_SQACC: begin
        sq_r[ci_r] <= sqp_r;
        t_r        <= t_r + T_W'(sqp_r);
        ci_r       <= (ci_r == 2'd2) ? 2'd0 : ci_r + 2'd1;
      end
      E_NCHK: begin
        n_r.x <= '0;
        n_r.y <= NRM_W'(ONE_Q14);
        n_r.z <= '0;
      end
      E_NWAIT: begin
        if (root_done) begin
          case (ci_r)
            2'd0:    n_r.x <= root_sgn;
            2'd1:    n_r.y <= root_sgn;
            default: n_r.z <= root_sgn;
          endcase
          ci_r <= ci_r + 2'd1;
        end
      end
      default: begin
      end
    endcase
  end

  assign rsp.done = done_r;
  assign rsp.n    = n_r;

endmodule

FILE: hw/rtl/heightmap_vertex_normals_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heightmap_vertex_normals_core
// Streams 8-bit height samples in raster order and returns the Q1.14 surface
// normal of every pixel, border pixels as (0,1,0).
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake           Payload
//   in_      slave      in_tvalid/tready    tdata[7:0] height_sample
//   out_     master     out_tvalid/tready   tdata col,row,nx,ny,nz; tlast
//   cfg_     slave      cfg_valid/ready     cfg_index, cfg_data
//
// One item is in work at a time. An item is taken in the idle state, its two
// line buffer bytes are read from the line RAM in the next cycle, and any
// results are then handed to the output register, one per free slot.
// A border-only item skips the normal engine. An interior pixel adds it: up
// to 27 runs of the shared 15-step root unit plus the cross-product and
// square passes. Reset is synchronous and clears counters, the window and
// the control state; the line RAM holds no reset. A stalled output holds its
// last result while the next input item may already be taken.
// ----------------------------------------------------------------------------
module heightmap_vertex_normals_core
  import hvn_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // height_sample [7:0]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // pixel_col [9:0], pixel_row [21:10], normal_x [37:22], normal_y [53:38],
  // normal_z [69:54], zero fill [71:70]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IW-1:0]      cfg_index,
  input  logic [CFG_DW-1:0]      cfg_data
);

  localparam int CNT_W  = $clog2(MAX_WIDTH);
  localparam int WC_W   = ($clog2(MAX_WIDTH + 1) > IW_W) ? $clog2(MAX_WIDTH + 1) : IW_W;
  localparam int COLX_W = (CNT_W > COL_W) ? CNT_W : COL_W;

  top_state_t st_r, st_nxt;

  logic [IW_W-1:0]      img_w_r;
  logic [IH_W-1:0]      img_h_r;
  logic [CNT_W-1:0]     col_r;
  logic [ROW_W-1:0]     row_r;
  logic [CNT_W-1:0]     c_r;
  logic [ROW_W-1:0]     r_r;
  logic [HGT_W-1:0]     bot_r;
  logic                 lcol_r, lrow_r;
  logic [5:0][HGT_W-1:0] win_r;
  logic [2:0]           pend_r;
  logic                 first_int_r;
  normal_t              nrm_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic                 out_tlast_r, out_valid_r;

  logic [WC_W-1:0]      wx, w_eff;
  logic [IH_W-1:0]      h_eff;
  logic                 last_col, last_row;
  logic                 in_acc, out_load;
  logic [15:0]          line_rdata;
  logic [HGT_W-1:0]     top_h, mid_h;
  logic [2:0]           pend_new, pick, pend_rem;
  logic                 need_int;
  logic [COLX_W-1:0]    res_col_x;
  logic [ROW_W-1:0]     res_row;
  normal_t              res_n, flat_n;
  eng_req_t             eng_req;
  eng_rsp_t             eng_rsp;

  // Clamp the registers to the supported frame size.
  always_comb begin
    wx    = WC_W'(img_w_r);
    if (wx < WC_W'(3)) begin
      w_eff = WC_W'(3);
    end else if (wx > WC_W'(MAX_WIDTH)) begin
      w_eff = WC_W'(MAX_WIDTH);
    end else begin
      w_eff = wx;
    end
    if (img_h_r < IH_W'(3)) begin
      h_eff = IH_W'(3);
    end else if (img_h_r > IH_W'(ROW_LIMIT)) begin
      h_eff = IH_W'(ROW_LIMIT);
    end else begin
      h_eff = img_h_r;
    end
    last_col = WC_W'(col_r) >= (w_eff - WC_W'(1));
    last_row = IH_W'(row_r) >= (h_eff - IH_W'(1));
  end

  assign in_tready = (st_r == T_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Line RAM: upper byte is the row two above, lower byte the row above.
  hvn_ram #(
    .WIDTH (16),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (st_r == T_READ),
    .waddr (c_r),
    .wdata ({mid_h, bot_r}),
    .raddr (col_r),
    .rdata (line_rdata)
  );

  assign top_h = line_rdata[15:8];
  assign mid_h = line_rdata[7:0];

  // Results of this item, in output order: the first one (a border pixel
  // of row 0 or column 0, or the interior pixel), the last-column border
  // pixel of the row above, and on the last row the pixel itself.
  always_comb begin
    need_int    = (r_r >= ROW_W'(2)) && (c_r >= CNT_W'(2));
    pend_new[0] = (r_r == '0) || ((r_r >= ROW_W'(2)) && ((c_r == '0) || need_int));
    pend_new[1] = (r_r >= ROW_W'(2)) && lcol_r && (c_r != '0);
    pend_new[2] = lrow_r && (r_r != '0);
  end

  always_comb begin
    eng_req.start = (st_r == T_READ) && need_int;
    for (int j = 0; j < 3; j++) begin
      eng_req.h[j*3]   = win_r[j];
      eng_req.h[j*3+1] = win_r[3+j];
    end
    eng_req.h[2] = top_h;
    eng_req.h[5] = mid_h;
    eng_req.h[8] = bot_r;
  end

  hvn_normal u_normal (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (eng_req),
    .rsp   (eng_rsp)
  );

  // Pick the earliest pending result and build its payload.
  always_comb begin
    if (pend_r[0]) begin
      pick = 3'b001;
    end else if (pend_r[1]) begin
      pick = 3'b010;
    end else begin
      pick = 3'b100;
    end
    pend_rem = pend_r & ~pick;
    flat_n.x = '0;
    flat_n.y = NRM_W'(ONE_Q14);
    flat_n.z = '0;
    res_n    = flat_n;
    case (pick)
      3'b001: begin
        if (r_r == '0) begin
          res_col_x = COLX_W'(c_r);
          res_row   = '0;
        end else if (first_int_r) begin
          res_col_x = COLX_W'(c_r - CNT_W'(1));
          res_row   = r_r - ROW_W'(1);
          res_n     = nrm_r;
        end else begin
          res_col_x = '0;
          res_row   = r_r - ROW_W'(1);
        end
      end
      3'b010: begin
        res_col_x = COLX_W'(c_r);
        res_row   = r_r - ROW_W'(1);
      end
      default: begin
        res_col_x = COLX_W'(c_r);
        res_row   = r_r;
      end
    endcase
    out_load = (st_r == T_EMIT) && (!out_valid_r || out_tready);
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      T_IDLE: if (in_acc) st_nxt = T_READ;
      T_READ: begin
        if (need_int) begin
          st_nxt = T_CALC;
        end else if (pend_new != '0) begin
          st_nxt = T_EMIT;
        end else begin
          st_nxt = T_IDLE;
        end
      end
      T_CALC: if (eng_rsp.done) st_nxt = T_EMIT;
      T_EMIT: if (out_load && (pend_rem == '0)) st_nxt = T_IDLE;
      default: st_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= T_IDLE;
      img_w_r     <= IMAGE_WIDTH_RST;
      img_h_r     <= IMAGE_HEIGHT_RST;
      col_r       <= '0;
      row_r       <= '0;
      win_r       <= '0;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:  img_w_r <= cfg_data[IW_W-1:0];
          REG_IMAGE_HEIGHT: img_h_r <= cfg_data[IH_W-1:0];
          default: begin
          end
        endcase
      end
      if (in_acc) begin
        if (last_col) begin
          col_r <= '0;
          row_r <= last_row ? '0 : row_r + ROW_W'(1);
        end else begin
          col_r <= col_r + CNT_W'(1);
        end
      end
      if (st_r == T_READ) begin
        win_r  <= {bot_r, mid_h, top_h, win_r[5], win_r[4], win_r[3]};
        pend_r <= pend_new;
      end else if (out_load) begin
        pend_r <= pend_rem;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (in_acc) begin
      c_r    <= col_r;
      r_r    <= row_r;
      bot_r  <= in_tdata[HGT_W-1:0];
      lcol_r <= last_col;
      lrow_r <= last_row;
    end
    if (st_r == T_READ) begin
      first_int_r <= need_int;
    end
    if (eng_rsp.done) begin
      nrm_r <= eng_rsp.n;
    end
    if (out_load) begin
      out_tdata_r <= {2'b00, res_n.z, res_n.y, res_n.x, res_row, res_col_x[COL_W-1:0]};
      out_tlast_r <= (pend_rem == '0);
    end
  end

  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;
  assign out_tvalid = out_valid_r;

endmodule

FILE: hw/rtl/hvn_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hvn_checker
// Port-level checks of the normal core, bound to the top level.
// ----------------------------------------------------------------------------
module hvn_checker
  import hvn_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tlast,
  input logic                   out_tvalid,
  input logic                   out_tready
);

  // Each item goes through a line RAM read, so the input is not ready in the cycle after it is taken.
  a_in_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken on two consecutive cycles");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[37:22]) <= 16'sd16384) &&
                   ($signed(out_tdata[37:22]) >= -16'sd16384) &&
                   ($signed(out_tdata[53:38]) <= 16'sd16384) &&
                   ($signed(out_tdata[53:38]) >= -16'sd16384) &&
                   ($signed(out_tdata[69:54]) <= 16'sd16384) &&
                   ($signed(out_tdata[69:54]) >= -16'sd16384) &&
                   (out_tdata[71:70] == 2'b00))
    else $error("normal component out of Q1.14 range");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("core not idle after reset");

endmodule

bind heightmap_vertex_normals_core hvn_checker u_hvn_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
